// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while dis is high.
`define ASSERT_IMPLY(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("%m: label failed");

// Next-cycle implication, disabled while dis is high.
`define ASSERT_NEXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("%m: label failed");

`endif

// File: rtl/tlssni_pkg.sv
// Types and constants shared by the ClientHello server-name parser.
package tlssni_pkg;

    // Fixed field positions and protocol codes
    localparam logic [15:0] MIN_LEN         = 16'd47;
    localparam logic [7:0]  CT_HANDSHAKE    = 8'd22;
    localparam logic [7:0]  HS_CLIENT_HELLO = 8'd1;
    localparam logic [15:0] HS_TYPE_POS     = 16'd5;
    localparam logic [15:0] SID_LEN_POS     = 16'd43;
    localparam logic [16:0] SID_START       = 17'd44;
    localparam logic [15:0] EXT_SERVER_NAME = 16'h0000;
    localparam logic [15:0] SNI_MIN_EXT_LEN = 16'd5;

    // Parse phase, one-hot
    typedef enum logic [13:0] {
        PH_HDR     = 14'b00000000000001,
        PH_CIPH_HI = 14'b00000000000010,
        PH_CIPH_LO = 14'b00000000000100,
        PH_COMP    = 14'b00000000001000,
        PH_EXTL_HI = 14'b00000000010000,
        PH_EXTL_LO = 14'b00000000100000,
        PH_TYPE_HI = 14'b00000001000000,
        PH_TYPE_LO = 14'b00000010000000,
        PH_LEN_HI  = 14'b00000100000000,
        PH_LEN_LO  = 14'b00001000000000,
        PH_NLEN_HI = 14'b00010000000000,
        PH_NLEN_LO = 14'b00100000000000,
        PH_NAME    = 14'b01000000000000,
        PH_STOP    = 14'b10000000000000
    } t_phase;

    // One result word
    typedef struct packed {
        logic [7:0] name_byte;
        logic       found;
        logic       name_last;
    } t_result;

endpackage

// File: rtl/tlssni_in_reg.sv
// Input register stage holding one payload byte and its length.
module tlssni_in_reg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic [15:0] i_payload_len,
    input  logic        i_take,
    output logic        o_valid,
    output logic [7:0]  o_data_byte,
    output logic [15:0] o_payload_len
);

    logic        r_valid;
    logic [7:0]  r_data;
    logic [15:0] r_len;
    logic        load;

    assign o_ready = !r_valid || i_take;
    assign load    = i_valid && o_ready;

    // Occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= i_data_byte;
            r_len  <= i_payload_len;
        end
    end

    assign o_valid       = r_valid;
    assign o_data_byte   = r_data;
    assign o_payload_len = r_len;

endmodule

// File: rtl/tlssni_parse_core.sv
// Parse state and combinational step logic for one payload byte.
module tlssni_parse_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [7:0]           i_data_byte,
    input  logic [15:0]          i_payload_len,
    input  logic                 i_out_room,
    output logic                 o_step,
    output logic                 o_res_valid,
    output tlssni_pkg::t_result  o_res
);

    logic [15:0]        r_idx, n_idx;
    logic [15:0]        r_len, n_len;
    tlssni_pkg::t_phase r_phase, n_phase;
    logic [16:0]        r_target, n_target;
    logic [15:0]        r_acc, n_acc;
    logic [16:0]        r_block_end, n_block_end;
    logic [16:0]        r_ext_end, n_ext_end;
    logic [15:0]        r_kind, n_kind;
    logic [15:0]        r_rem, n_rem;
    logic               r_done, n_done;

    logic               first;
    logic [15:0]        len_cur;
    tlssni_pkg::t_phase ph_cur;
    logic               done_cur;
    logic [16:0]        idx1;
    logic               hit;
    logic [15:0]        acc_new;
    logic [16:0]        pos_acc;
    logic [16:0]        pos_comp;
    logic [16:0]        pos_sid;
    logic [17:0]        len18;
    logic               is_last;
    logic               name_hit;
    logic               has_result;

    // Per-payload start values
    assign first    = (r_idx == 16'd0);
    assign len_cur  = first ? ((i_payload_len == 16'd0) ? 16'd1 : i_payload_len) : r_len;
    assign ph_cur   = first ? tlssni_pkg::PH_HDR : r_phase;
    assign done_cur = first ? 1'b0 : r_done;

    // Position arithmetic
    assign idx1     = {1'b0, r_idx} + 17'd1;
    assign hit      = ({1'b0, r_idx} == r_target);
    assign acc_new  = {r_acc[7:0], i_data_byte};
    assign pos_acc  = idx1 + {1'b0, acc_new};
    assign pos_comp = idx1 + {9'd0, i_data_byte};
    assign pos_sid  = tlssni_pkg::SID_START + {9'd0, i_data_byte};
    assign len18    = {2'b00, len_cur};
    assign is_last  = (idx1 >= {1'b0, len_cur});

    // Result selection
    assign name_hit   = (ph_cur == tlssni_pkg::PH_NAME) && hit;
    assign has_result = name_hit || (is_last && !done_cur);
    assign o_step     = i_valid && (!has_result || i_out_room);
    assign o_res_valid = o_step && has_result;

    always_comb begin
        if (name_hit) begin
            o_res.name_byte = i_data_byte;
            o_res.found     = 1'b1;
            o_res.name_last = (r_rem == 16'd1);
        end else begin
            o_res.name_byte = 8'd0;
            o_res.found     = 1'b0;
            o_res.name_last = 1'b1;
        end
    end

    // Next state for one byte
    always_comb begin
        n_idx       = is_last ? 16'd0 : idx1[15:0];
        n_len       = len_cur;
        n_phase     = ph_cur;
        n_target    = r_target;
        n_acc       = r_acc;
        n_block_end = r_block_end;
        n_ext_end   = r_ext_end;
        n_kind      = r_kind;
        n_rem       = r_rem;
        n_done      = done_cur;

        if (ph_cur == tlssni_pkg::PH_HDR) begin
            // Fixed record and handshake header checks
            if (r_idx == 16'd0) begin
                if (len_cur < tlssni_pkg::MIN_LEN
                        || i_data_byte != tlssni_pkg::CT_HANDSHAKE) begin
                    n_phase = tlssni_pkg::PH_STOP;
                end
            end else if (r_idx == tlssni_pkg::HS_TYPE_POS) begin
                if (i_data_byte != tlssni_pkg::HS_CLIENT_HELLO) begin
                    n_phase = tlssni_pkg::PH_STOP;
                end
            end else if (r_idx == tlssni_pkg::SID_LEN_POS) begin
                if ({1'b0, pos_sid} + 18'd2 > len18) begin
                    n_phase = tlssni_pkg::PH_STOP;
                end else begin
                    n_target = pos_sid;
                    n_phase  = tlssni_pkg::PH_CIPH_HI;
                end
            end
        end else if (ph_cur != tlssni_pkg::PH_STOP && hit) begin
            unique case (ph_cur)
                tlssni_pkg::PH_CIPH_HI: begin
                    n_acc    = {8'd0, i_data_byte};
                    n_target = idx1;
                    n_phase  = tlssni_pkg::PH_CIPH_LO;
                end
                tlssni_pkg::PH_EXTL_HI: begin
                    n_acc    = {8'd0, i_data_byte};
                    n_target = idx1;
                    n_phase  = tlssni_pkg::PH_EXTL_LO;
                end
                tlssni_pkg::PH_LEN_HI: begin
                    n_acc    = {8'd0, i_data_byte};
                    n_target = idx1;
                    n_phase  = tlssni_pkg::PH_LEN_LO;
                end
                tlssni_pkg::PH_NLEN_HI: begin
                    n_acc    = {8'd0, i_data_byte};
                    n_target = idx1;
                    n_phase  = tlssni_pkg::PH_NLEN_LO;
                end
                tlssni_pkg::PH_TYPE_HI: begin
                    n_kind   = {8'd0, i_data_byte};
                    n_target = idx1;
                    n_phase  = tlssni_pkg::PH_TYPE_LO;
                end
                tlssni_pkg::PH_TYPE_LO: begin
                    n_kind   = {r_kind[7:0], i_data_byte};
                    n_target = idx1;
                    n_phase  = tlssni_pkg::PH_LEN_HI;
                end
                tlssni_pkg::PH_CIPH_LO: begin
                    // skip cipher suites
                    n_acc = acc_new;
                    if ({1'b0, pos_acc} + 18'd1 > len18) begin
                        n_phase = tlssni_pkg::PH_STOP;
                    end else begin
                        n_target = pos_acc;
                        n_phase  = tlssni_pkg::PH_COMP;
                    end
                end
                tlssni_pkg::PH_COMP: begin
                    // skip compression methods
                    if ({1'b0, pos_comp} + 18'd2 > len18) begin
                        n_phase = tlssni_pkg::PH_STOP;
                    end else begin
                        n_target = pos_comp;
                        n_phase  = tlssni_pkg::PH_EXTL_HI;
                    end
                end
                tlssni_pkg::PH_EXTL_LO: begin
                    // extension block bounds
                    n_acc       = acc_new;
                    n_block_end = pos_acc;
                    if ({1'b0, pos_acc} > len18) begin
                        n_phase = tlssni_pkg::PH_STOP;
                    end else if ({1'b0, idx1} + 18'd4 <= {1'b0, pos_acc}) begin
                        n_target = idx1;
                        n_phase  = tlssni_pkg::PH_TYPE_HI;
                    end else begin
                        n_phase = tlssni_pkg::PH_STOP;
                    end
                end
                tlssni_pkg::PH_LEN_LO: begin
                    // one extension: server name or skip
                    n_acc     = acc_new;
                    n_ext_end = pos_acc;
                    if (pos_acc > r_block_end) begin
                        n_phase = tlssni_pkg::PH_STOP;
                    end else if (r_kind == tlssni_pkg::EXT_SERVER_NAME
                            && acc_new > tlssni_pkg::SNI_MIN_EXT_LEN) begin
                        n_target = idx1 + 17'd3;
                        n_phase  = tlssni_pkg::PH_NLEN_HI;
                    end else if ({1'b0, pos_acc} + 18'd4 <= {1'b0, r_block_end}) begin
                        n_target = pos_acc;
                        n_phase  = tlssni_pkg::PH_TYPE_HI;
                    end else begin
                        n_phase = tlssni_pkg::PH_STOP;
                    end
                end
                tlssni_pkg::PH_NLEN_LO: begin
                    // name length; an oversize name is passed over
                    n_acc = acc_new;
                    if (pos_acc <= r_block_end) begin
                        if (acc_new == 16'd0) begin
                            n_phase = tlssni_pkg::PH_STOP;
                        end else begin
                            n_rem    = acc_new;
                            n_target = idx1;
                            n_done   = 1'b1;
                            n_phase  = tlssni_pkg::PH_NAME;
                        end
                    end else if ({1'b0, r_ext_end} + 18'd4 <= {1'b0, r_block_end}) begin
                        n_target = r_ext_end;
                        n_phase  = tlssni_pkg::PH_TYPE_HI;
                    end else begin
                        n_phase = tlssni_pkg::PH_STOP;
                    end
                end
                tlssni_pkg::PH_NAME: begin
                    n_rem    = r_rem - 16'd1;
                    n_target = idx1;
                    if (r_rem == 16'd1) begin
                        n_phase = tlssni_pkg::PH_STOP;
                    end
                end
                default: begin
                    n_phase = tlssni_pkg::PH_STOP;
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 16'd0;
            r_len       <= 16'd0;
            r_phase     <= tlssni_pkg::PH_HDR;
            r_target    <= 17'd0;
            r_acc       <= 16'd0;
            r_block_end <= 17'd0;
            r_ext_end   <= 17'd0;
            r_kind      <= 16'd0;
            r_rem       <= 16'd0;
            r_done      <= 1'b0;
        end else if (o_step) begin
            r_idx       <= n_idx;
            r_len       <= n_len;
            r_phase     <= n_phase;
            r_target    <= n_target;
            r_acc       <= n_acc;
            r_block_end <= n_block_end;
            r_ext_end   <= n_ext_end;
            r_kind      <= n_kind;
            r_rem       <= n_rem;
            r_done      <= n_done;
        end
    end

endmodule

// File: rtl/tlssni_out_reg.sv
// Output register holding one result word.
module tlssni_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  tlssni_pkg::t_result i_res,
    output logic                o_room,
    output logic                o_valid,
    input  logic                i_ready,
    output tlssni_pkg::t_result o_res
);

    logic                r_valid;
    tlssni_pkg::t_result r_res;

    assign o_room = !r_valid || i_ready;

    // Occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// File: rtl/tls_client_hello_sni_parser.sv
// Top level of the ClientHello server-name parser: input register, step logic, output register.
// A byte's result word reaches the outputs through the input register and then the output register.
// Throughput: one byte per cycle; the step logic stalls only when a byte that
// yields a result meets a full, unread output register.
// At most one result word per byte. Reset (synchronous, active low) empties
// both register stages and returns the parser to the record header.
module tls_client_hello_sni_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic [15:0] i_payload_len,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_name_byte,
    output logic        o_found,
    output logic        o_name_last
);

    logic                q_valid;
    logic [7:0]          q_data;
    logic [15:0]         q_len;
    logic                step;
    logic                res_valid;
    logic                out_room;
    tlssni_pkg::t_result res;
    tlssni_pkg::t_result out_res;

    tlssni_in_reg u_in (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_ready       (o_in_ready),
        .i_data_byte   (i_data_byte),
        .i_payload_len (i_payload_len),
        .i_take        (step),
        .o_valid       (q_valid),
        .o_data_byte   (q_data),
        .o_payload_len (q_len)
    );

    tlssni_parse_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (q_valid),
        .i_data_byte   (q_data),
        .i_payload_len (q_len),
        .i_out_room    (out_room),
        .o_step        (step),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    tlssni_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .o_room  (out_room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (out_res)
    );

    assign o_name_byte = out_res.name_byte;
    assign o_found     = out_res.found;
    assign o_name_last = out_res.name_last;

endmodule

// File: rtl/tlssni_checker.sv
// Port-level checks for the server-name parser, bound to the top level.
`include "assert_macros.svh"

module tlssni_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  o_name_byte,
    input logic        o_found,
    input logic        o_name_last
);

    // stalled result word holds
    `ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable({o_name_byte, o_found, o_name_last}))

    // reset empties the output
    `ASSERT_NEXT(a_rst_empty, i_clk, 1'b0, !i_rst_n, !o_out_valid)

    // not-found word is always final
    `ASSERT_IMPLY(a_nf_last, i_clk, !i_rst_n, o_out_valid && !o_found, o_name_last)

    // not-found word carries a zero byte
    `ASSERT_IMPLY(a_nf_zero, i_clk, !i_rst_n, o_out_valid && !o_found, o_name_byte == 8'd0)

endmodule

bind tls_client_hello_sni_parser tlssni_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_name_byte (o_name_byte),
    .o_found     (o_found),
    .o_name_last (o_name_last)
);

// File: test/tls_client_hello_sni_parser_tb.sv
// Server-name parser testbench: directed and random payloads, predicted words, checks.
module tls_client_hello_sni_parser_tb;

    // Payload shapes produced by the stimulus generator
    typedef enum int {
        K_GOOD, K_NOFIT, K_EMPTY, K_EXT_OVER, K_BLK_PAST, K_SID_PAST, K_CIPH_PAST,
        K_BAD_CT, K_BAD_HS, K_TRUNC, K_NO_SNI, K_NOISE, K_ZERO_LEN
    } t_ch_kind;
    localparam int NUM_KINDS = K_ZERO_LEN + 1;

    // One input word plus the idling it is sent with
    typedef struct {
        logic [7:0]  data;
        logic [15:0] plen;
        int          gap_pct;
        int          stall_pct;
        bit          hold;
        bit          drain;
    } t_hello_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [7:0]  i_data_byte = '0;
    logic [15:0] i_payload_len = '0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [7:0]  o_name_byte;
    logic        o_found;
    logic        o_name_last;

    t_hello_byte         byte_backlog[$];
    tlssni_pkg::t_result sni_words_due[$];
    logic [7:0]          pkt[$];
    int                  err_count = 0;

    // generator settings for the payload being queued
    int cur_gap = 0;
    int cur_stall = 0;
    bit hold_next = 1'b0;
    bit drain_next = 1'b0;
    int byte_total = 0;

    // driver / monitor handshake helpers
    bit                  offered_hold = 1'b0;
    int                  offered_stall = 0;
    int                  stall_pct_now = 0;
    logic                hold_req = 1'b0;
    int                  hold_left = 0;
    bit                  send_now;
    t_hello_byte         next_byte;
    tlssni_pkg::t_result due_word;
    tlssni_pkg::t_result want;

    // Parser shadow state
    logic [15:0]        hello_pos = '0;
    logic [15:0]        hello_len = '0;
    tlssni_pkg::t_phase hello_phase = tlssni_pkg::PH_HDR;
    logic [16:0]        field_at = '0;
    logic [15:0]        len_acc = '0;
    logic [16:0]        ext_block_end = '0;
    logic [16:0]        ext_stop = '0;
    logic [15:0]        shadow_kind = '0;
    logic [15:0]        name_left = '0;
    bit                 name_started = 1'b0;

    tls_client_hello_sni_parser uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_byte  (i_data_byte),
        .i_payload_len(i_payload_len),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_name_byte  (o_name_byte),
        .o_found      (o_found),
        .o_name_last  (o_name_last)
    );

    always #5 i_clk = ~i_clk;

    // Start the next extension header, or stop if it cannot fit in the block
    function automatic void open_extension(input int unsigned at);
        if (at + 4 <= ext_block_end) begin
            field_at = 17'(at);
            hello_phase = tlssni_pkg::PH_TYPE_HI;
        end else begin
            hello_phase = tlssni_pkg::PH_STOP;
        end
    endfunction

    // Advance the shadow parser by one byte; returns 1 when a word is due
    function automatic bit predict_sni_byte(input logic [7:0] b, input logic [15:0] plen,
                                            output tlssni_pkg::t_result r);
        int unsigned idx;
        int unsigned len;
        int unsigned at;
        bit hit;
        hit = 1'b0;
        r = '0;
        if (hello_pos == 16'd0) begin
            hello_len = (plen == 16'd0) ? 16'd1 : plen;
            hello_phase = tlssni_pkg::PH_HDR;
            name_started = 1'b0;
        end
        idx = hello_pos;
        len = hello_len;

        if (hello_phase == tlssni_pkg::PH_HDR) begin
            // fixed-position checks in the record and handshake headers
            if (idx == 0) begin
                if (len < tlssni_pkg::MIN_LEN || b != tlssni_pkg::CT_HANDSHAKE)
                    hello_phase = tlssni_pkg::PH_STOP;
            end else if (idx == tlssni_pkg::HS_TYPE_POS) begin
                if (b != tlssni_pkg::HS_CLIENT_HELLO) hello_phase = tlssni_pkg::PH_STOP;
            end else if (idx == tlssni_pkg::SID_LEN_POS) begin
                at = tlssni_pkg::SID_START + b;
                if (at + 2 > len) begin
                    hello_phase = tlssni_pkg::PH_STOP;
                end else begin
                    field_at = 17'(at);
                    hello_phase = tlssni_pkg::PH_CIPH_HI;
                end
            end
        end else if (hello_phase != tlssni_pkg::PH_STOP && idx == field_at) begin
            case (hello_phase)
                tlssni_pkg::PH_CIPH_HI, tlssni_pkg::PH_EXTL_HI,
                tlssni_pkg::PH_LEN_HI, tlssni_pkg::PH_NLEN_HI: begin
                    len_acc = {8'h00, b};
                    field_at = 17'(idx + 1);
                    unique case (hello_phase)
                        tlssni_pkg::PH_CIPH_HI: hello_phase = tlssni_pkg::PH_CIPH_LO;
                        tlssni_pkg::PH_EXTL_HI: hello_phase = tlssni_pkg::PH_EXTL_LO;
                        tlssni_pkg::PH_LEN_HI:  hello_phase = tlssni_pkg::PH_LEN_LO;
                        default:                hello_phase = tlssni_pkg::PH_NLEN_LO;
                    endcase
                end
                tlssni_pkg::PH_TYPE_HI: begin
                    shadow_kind = {8'h00, b};
                    field_at = 17'(idx + 1);
                    hello_phase = tlssni_pkg::PH_TYPE_LO;
                end
                tlssni_pkg::PH_TYPE_LO: begin
                    shadow_kind = {shadow_kind[7:0], b};
                    field_at = 17'(idx + 1);
                    hello_phase = tlssni_pkg::PH_LEN_HI;
                end
                tlssni_pkg::PH_CIPH_LO: begin
                    len_acc = {len_acc[7:0], b};
                    at = idx + 1 + len_acc;
                    if (at + 1 > len) begin
                        hello_phase = tlssni_pkg::PH_STOP;
                    end else begin
                        field_at = 17'(at);
                        hello_phase = tlssni_pkg::PH_COMP;
                    end
                end
                tlssni_pkg::PH_COMP: begin
                    at = idx + 1 + b;
                    if (at + 2 > len) begin
                        hello_phase = tlssni_pkg::PH_STOP;
                    end else begin
                        field_at = 17'(at);
                        hello_phase = tlssni_pkg::PH_EXTL_HI;
                    end
                end
                tlssni_pkg::PH_EXTL_LO: begin
                    len_acc = {len_acc[7:0], b};
                    at = idx + 1;
                    ext_block_end = 17'(at + len_acc);
                    if (ext_block_end > len) hello_phase = tlssni_pkg::PH_STOP;
                    else open_extension(at);
                end
                tlssni_pkg::PH_LEN_LO: begin
                    len_acc = {len_acc[7:0], b};
                    at = idx + 1;
                    ext_stop = 17'(at + len_acc);
                    if (ext_stop > ext_block_end) begin
                        hello_phase = tlssni_pkg::PH_STOP;
                    end else if (shadow_kind == tlssni_pkg::EXT_SERVER_NAME
                            && len_acc > tlssni_pkg::SNI_MIN_EXT_LEN) begin
                        // skip list length and name type
                        field_at = 17'(at + 3);
                        hello_phase = tlssni_pkg::PH_NLEN_HI;
                    end else begin
                        open_extension(ext_stop);
                    end
                end
                tlssni_pkg::PH_NLEN_LO: begin
                    len_acc = {len_acc[7:0], b};
                    at = idx + 1;
                    if (at + len_acc <= ext_block_end) begin
                        if (len_acc == 16'd0) begin
                            hello_phase = tlssni_pkg::PH_STOP;
                        end else begin
                            name_left = len_acc;
                            field_at = 17'(at);
                            name_started = 1'b1;
                            hello_phase = tlssni_pkg::PH_NAME;
                        end
                    end else begin
                        open_extension(ext_stop);
                    end
                end
                tlssni_pkg::PH_NAME: begin
                    r.name_byte = b;
                    r.found = 1'b1;
                    r.name_last = (name_left == 16'd1);
                    hit = 1'b1;
                    name_left = name_left - 16'd1;
                    field_at = 17'(idx + 1);
                    if (name_left == 16'd0) hello_phase = tlssni_pkg::PH_STOP;
                end
                default: hello_phase = tlssni_pkg::PH_STOP;
            endcase
        end

        // end of payload: not-found word unless a name went out
        if (idx + 1 >= len) begin
            if (!name_started && !hit) begin
                r.name_byte = 8'h00;
                r.found = 1'b0;
                r.name_last = 1'b1;
                hit = 1'b1;
            end
            hello_pos = 16'd0;
        end else begin
            hello_pos = 16'(idx + 1);
        end
        return hit;
    endfunction

    task automatic add_random(input int n);
        repeat (n) pkt.push_back(8'($urandom));
    endtask

    task automatic add_u16(input int v);
        pkt.push_back(8'(v >> 8));
        pkt.push_back(8'(v));
    endtask

    // server_name extension: list length, host type, name length, name bytes
    task automatic add_sni(input int name_n, input int nlen_field);
        add_u16(tlssni_pkg::EXT_SERVER_NAME);
        add_u16(name_n + 5);
        add_u16(name_n + 3);
        pkt.push_back(8'h00);
        add_u16(nlen_field);
        add_random(name_n);
    endtask

    // filler extension; sometimes type 0 but too short to hold a name
    task automatic add_other_ext();
        int t;
        int n;
        t = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 65535);
        n = (t == 0) ? $urandom_range(0, 5) : $urandom_range(0, 4);
        add_u16(t);
        add_u16(n);
        add_random(n);
    endtask

    // Build one ClientHello-shaped payload into pkt
    task automatic build_hello(input t_ch_kind kind);
        int sid_n;
        int ciph_n;
        int comp_n;
        int n_ext;
        int sni_at;
        int blk_pos;
        int blk_len;
        int name_n;
        int cut;
        int e;
        pkt.delete();
        pkt.push_back(kind == K_BAD_CT ? 8'(22 + $urandom_range(1, 255))
                                       : tlssni_pkg::CT_HANDSHAKE);
        add_random(4);
        pkt.push_back(kind == K_BAD_HS ? 8'(1 + $urandom_range(1, 255))
                                       : tlssni_pkg::HS_CLIENT_HELLO);
        add_random(37);
        if (kind == K_SID_PAST) sid_n = $urandom_range(220, 255);
        else sid_n = ($urandom_range(7) == 0) ? 32 : $urandom_range(0, 4);
        pkt.push_back(8'(sid_n));
        add_random(kind == K_SID_PAST ? 4 : sid_n);
        ciph_n = 2 * $urandom_range(1, 3);
        add_u16(kind == K_CIPH_PAST ? $urandom_range(256, 65535) : ciph_n);
        add_random(ciph_n);
        comp_n = $urandom_range(1, 2);
        pkt.push_back(8'(comp_n));
        add_random(comp_n);
        blk_pos = pkt.size();
        add_u16(0);
        n_ext = $urandom_range(0, 2);
        sni_at = $urandom_range(0, n_ext);
        for (e = 0; e <= n_ext; e++) begin
            if (e == sni_at) begin
                name_n = ($urandom_range(9) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 12);
                case (kind)
                    K_NO_SNI: ;
                    K_EMPTY: add_sni(1, 0);
                    K_EXT_OVER: begin
                        // length runs past the extension block
                        add_u16($urandom_range(0, 65535));
                        add_u16(302);
                        add_random(2);
                    end
                    K_NOFIT: begin
                        // first name claims too much, a good one follows
                        add_sni(name_n, name_n + 300);
                        add_sni(name_n, name_n);
                    end
                    default: add_sni(name_n, name_n);
                endcase
            end
            if (e < n_ext) add_other_ext();
        end
        blk_len = pkt.size() - blk_pos - 2;
        if (kind == K_BLK_PAST) blk_len += $urandom_range(1, 200);
        pkt[blk_pos] = 8'(blk_len >> 8);
        pkt[blk_pos + 1] = 8'(blk_len);
        add_random($urandom_range(0, 3));
        if (kind == K_TRUNC) begin
            cut = $urandom_range(47, pkt.size() - 1);
            while (pkt.size() > cut) void'(pkt.pop_back());
        end
    endtask

    // Push pkt onto the backlog; payload_len is meaningful on the first word only
    task automatic queue_payload(input logic [15:0] plen);
        t_hello_byte it;
        int i;
        for (i = 0; i < pkt.size(); i++) begin
            it.data = pkt[i];
            it.plen = (i == 0) ? plen : 16'($urandom);
            it.gap_pct = cur_gap;
            it.stall_pct = cur_stall;
            it.hold = (i == 0) && hold_next;
            it.drain = (i == 0) && drain_next;
            byte_backlog.push_back(it);
        end
        hold_next = 1'b0;
        drain_next = 1'b0;
        byte_total += pkt.size();
    endtask

    // Stimulus, reset and end of run
    initial begin
        t_ch_kind kind;
        int pay_n;
        int ph;
        int last_ph;
        int n;

        // directed: zero length, one-byte payload, short payloads
        pkt = {8'h00};
        queue_payload(16'h0000);
        pkt = {8'hFF};
        queue_payload(16'd1);
        pkt = {tlssni_pkg::CT_HANDSHAKE, tlssni_pkg::HS_CLIENT_HELLO, 8'h00};
        queue_payload(16'd3);
        pkt.delete();
        pkt.push_back(tlssni_pkg::CT_HANDSHAKE);
        repeat (15) pkt.push_back(8'hFF);
        queue_payload(16'd16);

        // random: every shape once, then good hellos on 40 percent of picks
        last_ph = -1;
        for (pay_n = 0; byte_total < 1150; pay_n++) begin
            ph = byte_total * 4 / 1150;
            if (ph != last_ph) begin
                case (ph)
                    0: begin cur_gap = 0;  cur_stall = 0;  end
                    1: begin cur_gap = 45; cur_stall = 0;  end
                    2: begin cur_gap = 0;  cur_stall = 45; end
                    default: begin cur_gap = 16; cur_stall = 16; end
                endcase
                drain_next = 1'b1;
                last_ph = ph;
            end
            if (pay_n % 7 == 0) hold_next = 1'b1;
            if (pay_n < NUM_KINDS) kind = t_ch_kind'(pay_n);
            else if ($urandom_range(99) < 40) kind = K_GOOD;
            else kind = t_ch_kind'($urandom_range(1, NUM_KINDS - 1));

            if (kind == K_NOISE) begin
                n = $urandom_range(1, 60);
                pkt.delete();
                add_random(n);
                if ($urandom_range(1)) pkt[0] = tlssni_pkg::CT_HANDSHAKE;
                if (n > 5 && $urandom_range(1)) pkt[5] = tlssni_pkg::HS_CLIENT_HELLO;
                queue_payload(16'(n));
            end else if (kind == K_ZERO_LEN) begin
                pkt.delete();
                add_random(1);
                queue_payload(16'h0000);
            end else begin
                build_hello(kind);
                queue_payload(16'(pkt.size()));
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_backlog.size() != 0 || i_in_valid) @(posedge i_clk);
        while (sni_words_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    // Driver: predict on acceptance, then offer the next word or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            hold_req <= 1'b0;
        end else begin
            hold_req <= i_in_valid && o_in_ready && offered_hold;
            if (i_in_valid && o_in_ready) begin
                stall_pct_now <= offered_stall;
                if (predict_sni_byte(i_data_byte, i_payload_len, due_word))
                    sni_words_due.push_back(due_word);
            end
            if (!i_in_valid || o_in_ready) begin
                send_now = 1'b0;
                if (byte_backlog.size() != 0) begin
                    // a draining word waits until every due word has come back
                    if (byte_backlog[0].drain) send_now = (sni_words_due.size() == 0);
                    else send_now = ($urandom_range(99) >= byte_backlog[0].gap_pct);
                end
                if (send_now) begin
                    next_byte = byte_backlog.pop_front();
                    i_in_valid <= 1'b1;
                    i_data_byte <= next_byte.data;
                    i_payload_len <= next_byte.plen;
                    offered_hold <= next_byte.hold;
                    offered_stall <= next_byte.stall_pct;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_req) begin
            hold_left <= 100;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: compare each accepted word with the oldest due word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (sni_words_due.size() == 0) begin
                    $error("unexpected word: name_byte=%0h found=%0b name_last=%0b",
                           o_name_byte, o_found, o_name_last);
                    err_count++;
                end else begin
                    want = sni_words_due.pop_front();
                    if (o_name_byte !== want.name_byte) begin
                        $error("name_byte: expected %0h, got %0h", want.name_byte, o_name_byte);
                        err_count++;
                    end
                    if (o_found !== want.found) begin
                        $error("found: expected %0b, got %0b", want.found, o_found);
                        err_count++;
                    end
                    if (o_name_last !== want.name_last) begin
                        $error("name_last: expected %0b, got %0b", want.name_last, o_name_last);
                        err_count++;
                    end
                end
            end
            i_out_ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct_now);
        end
    end

endmodule
